@@ sv/multi_channel_task_watchdog_defines.svh @@
// Shared assertion macros for the watchdog checker.
`ifndef MULTI_CHANNEL_TASK_WATCHDOG_DEFINES_SVH
`define MULTI_CHANNEL_TASK_WATCHDOG_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define MCTW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("watchdog port check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define MCTW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("watchdog port check failed");

`endif

@@ sv/mctw_pkg.sv @@
package mctw_pkg;

  localparam int OP_W      = 3;
  localparam int CH_W      = 3;
  localparam int LIMIT_W   = 31;
  localparam int STAMP_W   = 32;
  localparam int COUNT_W   = 16;
  localparam int CFG_W     = 16;

  localparam logic [OP_W-1:0] OP_REGISTER = 3'd0;
  localparam logic [OP_W-1:0] OP_START    = 3'd1;
  localparam logic [OP_W-1:0] OP_END      = 3'd2;
  localparam logic [OP_W-1:0] OP_RECOVER  = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK     = 3'd4;

  localparam logic CAUSE_TIMEOUT = 1'b0;
  localparam logic CAUSE_RECOVER = 1'b1;

  localparam logic [CFG_W-1:0] PERIOD_RESET = 16'd1000;

  // One channel entry of the state memory.
  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [LIMIT_W-1:0] limit;
    logic [COUNT_W-1:0] miss;
  } entry_t;

endpackage

@@ sv/multi_channel_task_watchdog.sv @@
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid / in_ready    | op, channel, limit
// out     | output    | out_valid / out_ready  | recover_channel, overdue_count, cause, last
// cfg     | input     | cfg_we, no wait        | cfg_data (check period in ticks)
//
// Register, ignored ops and ticks without a check finish in the idle state.
// Start, end and recover also pass a read-modify-write state: one read of the
// channel memory, one write back. A tick that ends a check period walks the memory
// one channel a cycle while the result register does not stall.
// Reset is synchronous and holds in_ready low; it clears control state only.
// A recover item or a check walk waits on a full result register, in_ready low.
module multi_channel_task_watchdog #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mctw_pkg::OP_W-1:0]     op,
  input  logic [mctw_pkg::CH_W-1:0]     channel,
  input  logic [mctw_pkg::LIMIT_W-1:0]  limit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mctw_pkg::CH_W-1:0]     recover_channel,
  output logic [mctw_pkg::COUNT_W-1:0]  overdue_count,
  output logic                          cause,
  output logic                          last,
  input  logic                          cfg_we,
  input  logic [mctw_pkg::CFG_W-1:0]    cfg_data
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CHX_W = IDX_W + mctw_pkg::CH_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RMW   = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0] state, state_next;

  logic [mctw_pkg::CFG_W-1:0]   period_cfg;
  logic [mctw_pkg::STAMP_W-1:0] clock_now, clock_now_next;
  logic [mctw_pkg::CFG_W-1:0]   interval_left, interval_left_next;
  logic [mctw_pkg::CFG_W-1:0]   period_left;

  logic [NUM_CHANNELS-1:0] enrolled, enrolled_next;
  logic [NUM_CHANNELS-1:0] busy, busy_next;

  mctw_pkg::entry_t mem [NUM_CHANNELS];
  mctw_pkg::entry_t rd_data;
  mctw_pkg::entry_t mem_wdata;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] rd_addr;

  logic [mctw_pkg::OP_W-1:0] op_q;
  logic [IDX_W-1:0]          idx_q;
  logic [IDX_W-1:0]          scan_idx, scan_idx_next;

  logic [CHX_W-1:0] ch_wide;
  logic [IDX_W-1:0] in_idx;
  logic             in_range;

  // Held timeout result, sent once the next one (or the end of the walk) is known.
  logic                         pend_valid;
  logic [IDX_W-1:0]             pend_idx;
  logic [mctw_pkg::COUNT_W-1:0] pend_cnt;
  logic                         pend_load, pend_clear;

  logic                         out_load;
  logic [mctw_pkg::CH_W-1:0]    out_ch_d;
  logic [mctw_pkg::COUNT_W-1:0] out_cnt_d;
  logic                         out_cause_d, out_last_d;
  logic                         out_free;

  logic [mctw_pkg::STAMP_W-1:0] elapsed;
  logic [mctw_pkg::COUNT_W-1:0] miss_inc;
  logic                         scan_hit, scan_last, scan_stall;

  assign in_ready = (state == ST_IDLE) && !rst;
  assign out_free = !out_valid || out_ready;

  assign ch_wide  = {{IDX_W{1'b0}}, channel};
  assign in_range = (ch_wide < CHX_W'(NUM_CHANNELS));
  assign in_idx   = ch_wide[IDX_W-1:0];

  assign period_left = (interval_left != '0) ? interval_left :
                       (period_cfg != '0) ? period_cfg :
                       mctw_pkg::CFG_W'(1);

  assign elapsed   = clock_now - rd_data.stamp;
  assign miss_inc  = (rd_data.miss == '1) ? rd_data.miss : rd_data.miss + 1'b1;
  assign scan_hit  = enrolled[scan_idx] && busy[scan_idx] &&
                     (elapsed > {1'b0, rd_data.limit});
  assign scan_last = (scan_idx == IDX_W'(NUM_CHANNELS - 1));
  assign scan_stall = scan_hit && pend_valid && !out_free;

  always_comb begin
    state_next         = state;
    clock_now_next     = clock_now;
    interval_left_next = interval_left;
    enrolled_next      = enrolled;
    busy_next          = busy;
    scan_idx_next      = scan_idx;
    rd_addr            = scan_idx;
    mem_we             = 1'b0;
    mem_waddr          = idx_q;
    mem_wdata          = rd_data;
    pend_load          = 1'b0;
    pend_clear         = 1'b0;
    out_load           = 1'b0;
    out_ch_d           = mctw_pkg::CH_W'(pend_idx);
    out_cnt_d          = pend_cnt;
    out_cause_d        = mctw_pkg::CAUSE_TIMEOUT;
    out_last_d         = 1'b0;

    case (state)
      ST_IDLE: begin
        rd_addr = in_idx;
        if (in_valid && in_ready) begin
          case (op)
            mctw_pkg::OP_REGISTER: begin
              if (in_range && !enrolled[in_idx]) begin
                mem_we                = 1'b1;
                mem_waddr             = in_idx;
                mem_wdata.stamp       = clock_now;
                mem_wdata.limit       = limit;
                mem_wdata.miss        = '0;
                enrolled_next[in_idx] = 1'b1;
                busy_next[in_idx]     = 1'b0;
              end
            end
            mctw_pkg::OP_START, mctw_pkg::OP_END, mctw_pkg::OP_RECOVER: begin
              if (in_range && enrolled[in_idx]) begin
                state_next = ST_RMW;
              end
            end
            mctw_pkg::OP_TICK: begin
              clock_now_next     = clock_now + 1'b1;
              interval_left_next = period_left - 1'b1;
              if (period_left == mctw_pkg::CFG_W'(1)) begin
                rd_addr       = '0;
                scan_idx_next = '0;
                state_next    = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RMW: begin
        // keep the entry on the read port while the item waits
        rd_addr = idx_q;
        case (op_q)
          mctw_pkg::OP_START: begin
            mem_we           = 1'b1;
            mem_wdata.stamp  = clock_now;
            busy_next[idx_q] = 1'b1;
            state_next       = ST_IDLE;
          end
          mctw_pkg::OP_END: begin
            mem_we           = 1'b1;
            mem_wdata.miss   = '0;
            busy_next[idx_q] = 1'b0;
            state_next       = ST_IDLE;
          end
          mctw_pkg::OP_RECOVER: begin
            // hold until the result register can take the item
            if (out_free) begin
              mem_we         = 1'b1;
              mem_wdata.miss = '0;
              out_load       = 1'b1;
              out_ch_d       = mctw_pkg::CH_W'(idx_q);
              out_cnt_d      = '0;
              out_cause_d    = mctw_pkg::CAUSE_RECOVER;
              out_last_d     = 1'b1;
              state_next     = ST_IDLE;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        // read one entry ahead; re-read the current one while stalled or on the last entry
        rd_addr = (scan_stall || scan_last) ? scan_idx : scan_idx + 1'b1;
        if (!scan_stall) begin
          if (scan_hit) begin
            mem_we         = 1'b1;
            mem_waddr      = scan_idx;
            mem_wdata.miss = miss_inc;
            pend_load      = 1'b1;
            out_load       = pend_valid;
          end
          if (scan_last) begin
            state_next = ST_FLUSH;
          end else begin
            scan_idx_next = scan_idx + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          out_load   = 1'b1;
          out_last_d = 1'b1;
          pend_clear = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      period_cfg    <= mctw_pkg::PERIOD_RESET;
      clock_now     <= '0;
      interval_left <= '0;
      enrolled      <= '0;
      busy          <= '0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      clock_now     <= clock_now_next;
      interval_left <= interval_left_next;
      enrolled      <= enrolled_next;
      busy          <= busy_next;
      if (cfg_we) begin
        period_cfg <= cfg_data;
      end
      if (pend_load) begin
        pend_valid <= 1'b1;
      end else if (pend_clear) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    if (in_valid && in_ready) begin
      op_q  <= op;
      idx_q <= in_idx;
    end
    if (pend_load) begin
      pend_idx <= scan_idx;
      pend_cnt <= miss_inc;
    end
    if (out_load) begin
      recover_channel <= out_ch_d;
      overdue_count   <= out_cnt_d;
      cause           <= out_cause_d;
      last            <= out_last_d;
    end
  end

endmodule

@@ sv/mctw_checker.sv @@
`include "multi_channel_task_watchdog_defines.svh"

module mctw_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [mctw_pkg::OP_W-1:0]     op,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mctw_pkg::CH_W-1:0]     recover_channel,
  input logic [mctw_pkg::COUNT_W-1:0]  overdue_count,
  input logic                          cause,
  input logic                          last
);

  logic [mctw_pkg::CH_W+mctw_pkg::COUNT_W+1:0] out_payload;
  logic                                        recover_out;
  logic                                        timeout_out;
  logic                                        register_in;

  assign out_payload = {recover_channel, overdue_count, cause, last};
  assign recover_out = out_valid && (cause == mctw_pkg::CAUSE_RECOVER);
  assign timeout_out = out_valid && (cause == mctw_pkg::CAUSE_TIMEOUT);
  assign register_in = in_valid && in_ready && (op == mctw_pkg::OP_REGISTER);

  // a stalled result item keeps its payload
  `MCTW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))

  // a recovery request always reports a cleared count and ends its item
  `MCTW_ASSERT_NOW(a_recover_shape, recover_out, (overdue_count == '0) && last)

  // a timeout has been counted at least once
  `MCTW_ASSERT_NOW(a_timeout_count, timeout_out, overdue_count != '0)

  // a register op never produces a result in the following cycle
  `MCTW_ASSERT_NEXT(a_register_quiet, register_in && !out_valid, !out_valid)

endmodule

bind multi_channel_task_watchdog mctw_checker u_mctw_checker (.*);
